FILE: hw/rtl/bdhr_pkg.sv
`default_nettype none

package bdhr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_BUTTONS_DEF = 3;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned BTN_W   = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CIDX_W  = 2;

  // Config register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd50;

  // Config register indexes
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_REPEAT   = 2'd2;

  // Button codes
  localparam logic [BTN_W-1:0] BTN_MINUS = 2'd0;
  localparam logic [BTN_W-1:0] BTN_PLUS  = 2'd1;
  localparam logic [BTN_W-1:0] BTN_OK    = 2'd2;

  typedef enum logic [1:0] {
    ST_LOW  = 2'd0,
    ST_HIGH = 2'd1,
    ST_HOLD = 2'd2
  } dstate_e;

  // One per-button entry, as held in the state RAM
  typedef struct packed {
    logic [1:0]        state;
    logic              raw;
    logic [TIME_W-1:0] change_time;
  } btn_entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] repeat_ms;
  } cfg_t;

  // Event flags of one poll
  typedef struct packed {
    logic pressed;
    logic released;
    logic held_tick;
    logic commit;
    logic capsule_reset;
  } events_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bdhr_ram.sv
`default_nettype none

module bdhr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bdhr_update.sv
`default_nettype none

module bdhr_update #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire bdhr_pkg::btn_entry_t              entry_i,
  input  wire logic [bdhr_pkg::BTN_W-1:0]        button_i,
  input  wire logic                              level_i,
  input  wire logic [bdhr_pkg::TIME_W-1:0]       now_i,
  input  wire bdhr_pkg::cfg_t                    cfg_i,
  input  wire logic [COUNT_BITS-1:0]             count_i,
  output bdhr_pkg::btn_entry_t                   entry_o,
  output bdhr_pkg::events_t                      events_o,
  output logic      [COUNT_BITS-1:0]             count_o
);

  import bdhr_pkg::*;

  dstate_e           st_in;
  dstate_e           st;
  logic [TIME_W-1:0] ct;
  logic [TIME_W-1:0] diff;
  logic [COUNT_BITS-1:0] cnt1;
  logic              is_step;

  assign is_step = (button_i == BTN_PLUS) || (button_i == BTN_MINUS);

  always_comb begin
    unique case (entry_i.state)
      ST_HIGH: st_in = ST_HIGH;
      ST_HOLD: st_in = ST_HOLD;
      default: st_in = ST_LOW;
    endcase

    events_o = '0;
    st       = st_in;
    cnt1     = count_i;
    count_o  = count_i;

    // low level drops hold straight to low, no release
    if (!level_i && st == ST_HOLD) begin
      st = ST_LOW;
    end
    ct   = (level_i != entry_i.raw) ? now_i : entry_i.change_time;
    diff = now_i - ct;

    if (diff > TIME_W'(cfg_i.debounce_ms)) begin
      if (level_i && st == ST_LOW) begin
        st               = ST_HIGH;
        events_o.pressed = 1'b1;
        if (button_i == BTN_PLUS) begin
          cnt1 = count_i + COUNT_BITS'(1);
        end else if (button_i == BTN_MINUS) begin
          cnt1 = count_i - COUNT_BITS'(1);
        end
      end else if (!level_i && st == ST_HIGH) begin
        st                = ST_LOW;
        events_o.released = 1'b1;
        events_o.commit   = (button_i == BTN_OK);
      end
    end

    if (st == ST_HIGH && diff > TIME_W'(cfg_i.hold_ms)) begin
      st = ST_HOLD;
    end

    count_o = cnt1;
    if (st == ST_HOLD && diff > TIME_W'(cfg_i.repeat_ms)) begin
      events_o.held_tick = 1'b1;
      ct                 = now_i;
      if (button_i == BTN_OK) begin
        count_o                = '0;
        events_o.capsule_reset = 1'b1;
      end else if (is_step) begin
        count_o = (button_i == BTN_PLUS) ? cnt1 + COUNT_BITS'(1)
                                         : cnt1 - COUNT_BITS'(1);
      end
    end

    entry_o.state       = st;
    entry_o.raw         = level_i;
    entry_o.change_time = ct;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/button_debounce_hold_repeat_counter_unit.sv
`default_nettype none

// Debounced button poller with hold, auto-repeat and a shared up/down counter.
// Slave stream: one poll per transfer; tuser carries the button (0 minus,
// 1 plus, 2 ok), tdata the raw level and a wrapping millisecond timestamp.
// Master stream: one result per poll; tuser echoes the button, tdata holds
// the event flags and the counter value after the poll.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 debounce,
// 1 hold, 2 repeat time in ms); only while no poll is in flight.
// A result passes the state RAM read stage, then the output register.
// Throughput: one poll per cycle while the master side does not stall; a
// poll that follows its own button is served by forwarding the previous write.
// Per-button state lives in a RAM with a registered read; valid bits make
// unwritten entries read as zero, so reset needs no clearing pass.
// Reset: config back to 30/500/50 ms, counter zero, all buttons low.
// Stall: when the master side stalls, the output register holds, the
// in-flight poll waits in the RAM-read stage and s_axis_tready falls.
module button_debounce_hold_repeat_counter_unit #(
  parameter int unsigned NUM_BUTTONS = bdhr_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned COUNT_BITS  = bdhr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave side
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [39:0]                   s_axis_tdata,  // level, now_ms, pad
  input  wire logic [bdhr_pkg::BTN_W-1:0]    s_axis_tuser,  // button
  // master side
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pressed, released, held_tick, count[15:0], commit, capsule_reset, pad
  output logic      [23:0]                   m_axis_tdata,
  output logic      [bdhr_pkg::BTN_W-1:0]    m_axis_tuser,  // which_button
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [bdhr_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [bdhr_pkg::CFG_W-1:0]    cfg_data_i
);

  import bdhr_pkg::*;

  localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned EW = $bits(btn_entry_t);

  // config registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.hold_ms     <= HOLD_RST;
      cfg_q.repeat_ms   <= REPEAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data_i;
        REG_HOLD:     cfg_q.hold_ms     <= cfg_data_i;
        REG_REPEAT:   cfg_q.repeat_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic in_xfer;
  logic s1_vld_q;
  logic s1_adv;
  logic out_vld_q;

  assign s1_adv        = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  logic          in_range;
  logic [AW-1:0] in_addr;

  assign in_range = 32'(s_axis_tuser) < NUM_BUTTONS;
  assign in_addr  = AW'(s_axis_tuser);

  // RAM-read stage registers
  logic [BTN_W-1:0]  s1_btn_q;
  logic              s1_lvl_q;
  logic [TIME_W-1:0] s1_now_q;
  logic              s1_inr_q;
  logic [AW-1:0]     s1_addr_q;
  logic              s1_rvld_q;

  // valid bits, one per entry
  logic [NUM_BUTTONS-1:0] ent_vld_q;

  // forward path for the write made at the read edge
  logic          fwd_vld_q;
  logic [AW-1:0] fwd_addr_q;
  btn_entry_t    fwd_data_q;

  logic [EW-1:0] ram_rdata;
  btn_entry_t    cur_entry;
  btn_entry_t    new_entry;
  events_t       ev;
  logic [COUNT_BITS-1:0] counter_q;
  logic [COUNT_BITS-1:0] count_new;
  logic          ram_we;

  assign ram_we = s1_vld_q && s1_adv && s1_inr_q;

  bdhr_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_BUTTONS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_addr_q),
    .wdata_i(new_entry),
    .re_i   (in_xfer && in_range),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (fwd_vld_q && fwd_addr_q == s1_addr_q) begin
      cur_entry = fwd_data_q;
    end else if (s1_rvld_q) begin
      cur_entry = btn_entry_t'(ram_rdata);
    end else begin
      cur_entry = '0;
    end
  end

  bdhr_update #(
    .COUNT_BITS(COUNT_BITS)
  ) u_update (
    .entry_i (cur_entry),
    .button_i(s1_btn_q),
    .level_i (s1_lvl_q),
    .now_i   (s1_now_q),
    .cfg_i   (cfg_q),
    .count_i (counter_q),
    .entry_o (new_entry),
    .events_o(ev),
    .count_o (count_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      ent_vld_q <= '0;
      fwd_vld_q <= 1'b0;
      counter_q <= '0;
    end else begin
      if (s1_adv || !s1_vld_q) begin
        s1_vld_q <= in_xfer;
      end
      if (ram_we) begin
        ent_vld_q[s1_addr_q] <= 1'b1;
      end
      if (in_xfer) begin
        fwd_vld_q <= ram_we;
      end
      if (s1_vld_q && s1_adv && s1_inr_q) begin
        counter_q <= count_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_btn_q   <= s_axis_tuser;
      s1_lvl_q   <= s_axis_tdata[0];
      s1_now_q   <= s_axis_tdata[TIME_W:1];
      s1_inr_q   <= in_range;
      s1_addr_q  <= in_addr;
      s1_rvld_q  <= in_range && ent_vld_q[in_addr];
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_entry;
    end
  end

  // output register
  events_t           out_ev_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic [BTN_W-1:0]  out_btn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_btn_q <= s1_btn_q;
      out_ev_q  <= s1_inr_q ? ev : '0;
      out_cnt_q <= s1_inr_q ? COUNT_W'(count_new) : COUNT_W'(counter_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_btn_q;
  assign m_axis_tdata  = {3'b000, out_ev_q.capsule_reset, out_ev_q.commit, out_cnt_q,
                          out_ev_q.held_tick, out_ev_q.released, out_ev_q.pressed};

`ifndef SYNTHESIS
  // a capsule reset always shows a cleared counter
  a_capres_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_ev_q.capsule_reset |-> out_cnt_q == '0)
    else $error("capsule reset with non-zero count");

  // commit comes only with a release of ok
  a_commit_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_ev_q.commit |-> out_ev_q.released && out_btn_q == BTN_OK)
    else $error("commit without ok release");

  // a stalled poll stays in the read stage unchanged
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_adv |=> s1_vld_q && $stable(s1_btn_q) && $stable(s1_now_q))
    else $error("read stage lost a stalled poll");

  // counter moves only when a poll leaves the read stage
  a_cnt_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && s1_adv) |=> $stable(counter_q))
    else $error("counter changed without a poll");
`endif

endmodule

`default_nettype wire

FILE: verif/button_debounce_hold_repeat_counter_unit_test.sv
`default_nettype none

module button_debounce_hold_repeat_counter_unit_test;
  import bdhr_pkg::*;

  // Out-of-range button index: the block must echo it and leave all state alone
  localparam logic [BTN_W-1:0]  BTN_NONE    = 2'd3;
  localparam logic [TIME_W-1:0] T_MAX       = '1;
  localparam int unsigned       CYCLE_LIMIT = 200000;
  localparam int unsigned       PHASE_POLLS = 72;
  // long receiver hold-off, so the pipe fills and s_axis_tready drops
  localparam int unsigned       STALL_AT    = 150;
  localparam int unsigned       STALL_LEN   = 300;

  // One result as the master side presents it
  typedef struct packed {
    logic [BTN_W-1:0]   which_button;
    logic               pressed;
    logic               released;
    logic               held_tick;
    logic [COUNT_W-1:0] count;
    logic               commit;
    logic               capsule_reset;
  } poll_report_t;

  // Tracks per-button debounce state and the shared counter; queues the
  // result each accepted poll should produce and checks results in order.
  class counter_scoreboard;
    logic [CFG_W-1:0]   debounce_ms;
    logic [CFG_W-1:0]   hold_ms;
    logic [CFG_W-1:0]   repeat_ms;
    dstate_e            level_state [NUM_BUTTONS_DEF];
    logic               last_level  [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0]  changed_at  [NUM_BUTTONS_DEF];
    logic [COUNT_W-1:0] tally;
    poll_report_t       awaited_reports [$];
    int unsigned        errors;

    function new();
      debounce_ms = DEBOUNCE_RST;
      hold_ms     = HOLD_RST;
      repeat_ms   = REPEAT_RST;
      for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
        level_state[i] = ST_LOW;
        last_level[i]  = 1'b0;
        changed_at[i]  = '0;
      end
      tally  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_DEBOUNCE: debounce_ms = value;
        REG_HOLD:     hold_ms     = value;
        REG_REPEAT:   repeat_ms   = value;
        default: ;
      endcase
    endfunction

    function void step_tally(logic [BTN_W-1:0] btn);
      if (btn == BTN_PLUS)
        tally = tally + 1'b1;
      else if (btn == BTN_MINUS)
        tally = tally - 1'b1;
    endfunction

    function int unsigned pending();
      return awaited_reports.size();
    endfunction

    function void note_poll(logic [BTN_W-1:0] btn, logic lvl, logic [TIME_W-1:0] now);
      poll_report_t      rep;
      dstate_e           st;
      logic [TIME_W-1:0] elapsed;
      rep = '0;
      rep.which_button = btn;
      if (btn < NUM_BUTTONS_DEF) begin
        st = level_state[btn];
        // dropping out of hold goes straight to low, no release
        if (!lvl && st == ST_HOLD)
          st = ST_LOW;
        if (lvl != last_level[btn])
          changed_at[btn] = now;
        elapsed = now - changed_at[btn];
        if (elapsed > debounce_ms) begin
          if (lvl && st == ST_LOW) begin
            st = ST_HIGH;
            rep.pressed = 1'b1;
            step_tally(btn);
          end else if (!lvl && st == ST_HIGH) begin
            st = ST_LOW;
            rep.released = 1'b1;
            rep.commit   = (btn == BTN_OK);
          end
        end
        if (st == ST_HIGH && elapsed > hold_ms)
          st = ST_HOLD;
        if (st == ST_HOLD && elapsed > repeat_ms) begin
          rep.held_tick = 1'b1;
          if (btn == BTN_OK) begin
            tally = '0;
            rep.capsule_reset = 1'b1;
          end else begin
            step_tally(btn);
          end
          changed_at[btn] = now;
        end
        level_state[btn] = st;
        last_level[btn]  = lvl;
      end
      rep.count = tally;
      awaited_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [BTN_W-1:0] user, logic [23:0] data);
      poll_report_t want;
      if (awaited_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, tuser %0d tdata %h", $time, user, data);
        return;
      end
      want = awaited_reports.pop_front();
      compare_field("which_button",  want.which_button,  user);
      compare_field("pressed",       want.pressed,       data[0]);
      compare_field("released",      want.released,      data[1]);
      compare_field("held_tick",     want.held_tick,     data[2]);
      compare_field("count",         want.count,         data[18:3]);
      compare_field("commit",        want.commit,        data[19]);
      compare_field("capsule_reset", want.capsule_reset, data[20]);
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata  = '0;  // level, now_ms[31:0], pad
  logic [BTN_W-1:0]   s_axis_tuser  = '0;  // button
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // pressed, released, held_tick, count[15:0], commit, capsule_reset, pad
  logic [23:0]        m_axis_tdata;
  logic [BTN_W-1:0]   m_axis_tuser;        // which_button
  logic               cfg_we_i      = 1'b0;
  logic [CIDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_W-1:0]   cfg_data_i    = '0;

  counter_scoreboard board;
  int unsigned       cycle_count  = 0;
  int unsigned       sent_count   = 0;
  int unsigned       results_seen = 0;
  int unsigned       stall_left   = 0;
  bit                stall_done   = 1'b0;
  logic              pin_level [4] = '{default: 1'b0};
  logic [TIME_W-1:0] clock_ms     = '0;

  button_debounce_hold_repeat_counter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Offer one poll; returns at the edge where the transfer happens. tvalid is
  // left high so back-to-back polls need no second assignment in one step.
  // Random idles are skipped for a stretch of polls in the middle of the run.
  task automatic send_poll(input logic [BTN_W-1:0] btn, input logic lvl,
                           input logic [TIME_W-1:0] ts);
    if (sent_count < 250 || sent_count >= 350) begin
      while ($urandom_range(0, 99) < 10) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ts, lvl};
    s_axis_tuser  <= btn;
    @(posedge clk_i);
    while (!s_axis_tready)
      @(posedge clk_i);
    board.note_poll(btn, lvl, ts);
    sent_count++;
  endtask

  // Sender waits for every outstanding result; the short tail covers the
  // RAM-read stage and output register before the config port is touched.
  task automatic drain();
    while (board.pending() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                            input logic [CFG_W-1:0] rep);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DEBOUNCE;
    cfg_data_i <= deb;
    @(posedge clk_i);
    cfg_idx_i  <= REG_HOLD;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_idx_i  <= REG_REPEAT;
    cfg_data_i <= rep;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.write_reg(REG_DEBOUNCE, deb);
    board.write_reg(REG_HOLD, hold);
    board.write_reg(REG_REPEAT, rep);
  endtask

  // Directed walk with reset timing (30/500/50 ms)
  task automatic run_directed();
    // plus: settle, press, enter hold with an immediate tick, repeat, drop out of hold
    send_poll(BTN_PLUS, 1'b1, 32'd1000);
    send_poll(BTN_PLUS, 1'b1, 32'd1031);
    send_poll(BTN_PLUS, 1'b1, 32'd1600);
    send_poll(BTN_PLUS, 1'b1, 32'd1660);
    send_poll(BTN_PLUS, 1'b0, 32'd1670);
    // minus: ordinary press and release
    send_poll(BTN_MINUS, 1'b1, 32'd1700);
    send_poll(BTN_MINUS, 1'b1, 32'd1800);
    send_poll(BTN_MINUS, 1'b0, 32'd1900);
    send_poll(BTN_MINUS, 1'b0, 32'd1950);
    // ok: press is ignored by the counter, release commits
    send_poll(BTN_OK, 1'b1, 32'd2000);
    send_poll(BTN_OK, 1'b1, 32'd2040);
    send_poll(BTN_OK, 1'b0, 32'd2100);
    send_poll(BTN_OK, 1'b0, 32'd2140);
    // ok: long gap gives press, hold and capsule reset at once; leave hold silently
    send_poll(BTN_OK, 1'b1, 32'd3000);
    send_poll(BTN_OK, 1'b1, 32'd4000);
    send_poll(BTN_OK, 1'b0, 32'd4100);
    // plus: press and tick in one poll, counter steps twice
    send_poll(BTN_PLUS, 1'b1, 32'd5000);
    send_poll(BTN_PLUS, 1'b1, 32'd6000);
    // out-of-range button at timestamp extremes
    send_poll(BTN_NONE, 1'b1, T_MAX);
    send_poll(BTN_NONE, 1'b0, '0);
    // minus press across the 2^32 wrap
    send_poll(BTN_MINUS, 1'b1, 32'hFFFF_FFF0);
    send_poll(BTN_MINUS, 1'b1, 32'h0000_0010);
    s_axis_tvalid <= 1'b0;
  endtask

  // Mostly coherent pin traces on a rising clock, time steps scaled to the
  // current timing so hold and repeat are reached; a little contact bounce,
  // some out-of-range buttons and some fully random polls as noise.
  task automatic run_random(input int unsigned polls);
    int unsigned      span;
    int unsigned      pick;
    logic [BTN_W-1:0] btn;
    logic             lvl;
    span = board.debounce_ms + board.repeat_ms + board.hold_ms / 6 + 2;
    clock_ms = $urandom();
    for (int i = 0; i < polls; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_poll(BTN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom());
      end else begin
        if (pick < 8)
          btn = BTN_NONE;
        else
          btn = BTN_W'($urandom_range(0, 2));
        clock_ms = clock_ms + $urandom_range(0, span);
        if ($urandom_range(0, 7) == 0)
          pin_level[btn] = ~pin_level[btn];
        lvl = pin_level[btn];
        if ($urandom_range(0, 19) == 0)
          lvl = ~lvl;
        send_poll(btn, lvl, clock_ms);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Result side: check each transfer, random back-pressure, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_result(m_axis_tuser, m_axis_tdata);
        results_seen++;
      end
      if (!stall_done && results_seen >= STALL_AT) begin
        stall_done    = 1'b1;
        stall_left    = STALL_LEN;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (results_seen >= 250 && results_seen < 350) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain();
    // timing extremes, reset values, tight values and a random mix
    set_timing(16'd0, 16'd0, 16'd0);
    run_random(PHASE_POLLS);
    drain();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_POLLS);
    drain();
    set_timing(DEBOUNCE_RST, HOLD_RST, REPEAT_RST);
    run_random(PHASE_POLLS);
    drain();
    set_timing(16'd1, 16'd20, 16'd3);
    run_random(PHASE_POLLS);
    drain();
    set_timing(CFG_W'($urandom_range(0, 50)), CFG_W'($urandom_range(0, 600)),
               CFG_W'($urandom_range(0, 80)));
    run_random(PHASE_POLLS);
    drain();
    set_timing(16'hFFFF, 16'd0, 16'hFFFF);
    run_random(PHASE_POLLS);
    drain();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/bdhr_pkg.sv
hw/rtl/bdhr_ram.sv
hw/rtl/bdhr_update.sv
hw/rtl/button_debounce_hold_repeat_counter_unit.sv
verif/button_debounce_hold_repeat_counter_unit_test.sv
